### rtl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Default geometry of the bitmap and the page size.
    localparam int MAP_WORDS_DEF  = 128;
    localparam int WORD_BITS_DEF  = 32;
    localparam int PAGE_SHIFT_DEF = 12;

    // Fixed field widths.
    localparam int KEND_W  = 25;
    localparam int FRAME_W = 12;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 3;

    // Width used for range compares; holds any frame count or frame number.
    localparam int CMP_W = 34;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_AT    = 2'd2,
        MODE_INIT  = 2'd3
    } t_mode;

    localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SKIPPED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_TAKEN     = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd5;
    localparam logic [STAT_W-1:0] ST_INIT      = 3'd6;

    typedef struct packed {
        logic [ADDR_W-1:0]  req_addr;
        logic [FRAME_W-1:0] page_frame;
        t_mode              mode;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               mapped;
        logic [STAT_W-1:0]  status;
    } t_result;

endpackage

### rtl/bfa_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_mem
// Bitmap store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: bitmap sweep, lowest-free scan, frame-to-word split
// and read-modify-write of single frame bits.
// ----------------------------------------------------------------------------
module bfa_ctrl #(
    parameter int MAP_WORDS  = 128,
    parameter int WORD_BITS  = 32,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic [bfa_pkg::KEND_W-1:0]                         i_kend,
    input  logic                                               i_req_valid,
    output logic                                               o_req_ready,
    input  bfa_pkg::t_req                                      i_req,
    output logic                                               o_res_valid,
    input  logic                                               i_res_ready,
    output bfa_pkg::t_result                                   o_res,
    output logic                                               o_mem_rd_en,
    output logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] o_mem_rd_addr,
    input  logic [WORD_BITS-1:0]                               i_mem_rd_data,
    output logic                                               o_mem_wr_en,
    output logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] o_mem_wr_addr,
    output logic [WORD_BITS-1:0]                               o_mem_wr_data
);

    import bfa_pkg::*;

    // WORD_BITS is a power of two, so a frame number splits into its word
    // index (upper bits) and its bit position (lower BW bits).
    localparam int FRAME_COUNT = MAP_WORDS * WORD_BITS;
    localparam int FCW         = $clog2(FRAME_COUNT + 1);
    localparam int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW          = $clog2(WORD_BITS);
    localparam int PAGE_MASK   = (1 << PAGE_SHIFT) - 1;

    localparam logic [AW-1:0]  LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [FCW-1:0] WB_STEP   = FCW'(WORD_BITS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state         r_state;
    t_mode          r_mode;
    t_result        r_res;
    logic [FRAME_W-1:0] r_pf;
    logic [FCW-1:0] r_frame;
    logic [BW-1:0]  r_rem;
    logic [AW-1:0]  r_q;
    logic [AW-1:0]  r_addr;
    logic [FCW-1:0] r_base;
    logic [AW-1:0]  r_caddr;
    logic [FCW-1:0] r_cbase;
    logic [FCW-1:0] r_n;
    logic           r_init_req;
    logic           r_dv;
    logic           r_last_iss;

    logic              w_full;
    logic [BW-1:0]     w_zero_idx;
    logic [WORD_BITS-1:0] w_init_word;
    logic              w_n_gt;
    logic [FCW-1:0]    w_diff;
    logic [CMP_W-1:0]  w_n_raw;
    logic [FCW-1:0]    w_n_cap;
    logic [CMP_W-1:0]  w_at_frame;
    logic              w_pf_range;
    logic              w_at_range;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic              w_hit;

    // Lowest clear bit of the word coming back from the bitmap.
    always_comb begin
        w_full     = (i_mem_rd_data == '1);
        w_zero_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_mem_rd_data[b]) begin
                w_zero_idx = BW'(b);
            end
        end
    end

    // Init sweep word: bit b is set when frame base + b lies below the limit.
    always_comb begin
        w_n_gt = (r_n > r_base);
        w_diff = r_n - r_base;
        for (int b = 0; b < WORD_BITS; b++) begin
            w_init_word[b] = w_n_gt && (w_diff > FCW'(b));
        end
    end

    always_comb begin
        w_n_raw    = (CMP_W'(i_kend) + CMP_W'(PAGE_MASK)) >> PAGE_SHIFT;
        w_n_cap    = (w_n_raw > CMP_W'(FRAME_COUNT)) ? FCW'(FRAME_COUNT) : FCW'(w_n_raw);
        w_at_frame = CMP_W'(i_req.req_addr >> PAGE_SHIFT);
        w_pf_range = (CMP_W'(i_req.page_frame) >= CMP_W'(FRAME_COUNT));
        w_at_range = (w_at_frame >= CMP_W'(FRAME_COUNT));
        w_bit_mask = WORD_BITS'(1) << r_rem;
        w_hit      = ((i_mem_rd_data & w_bit_mask) != '0);
    end

    // Memory port control.
    always_comb begin
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_addr;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_addr;
        o_mem_wr_data = w_init_word;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_wr_en = 1'b1;
            end
            S_SCAN: begin
                o_mem_rd_en   = !r_last_iss;
                o_mem_wr_en   = r_dv && !w_full;
                o_mem_wr_addr = r_caddr;
                o_mem_wr_data = i_mem_rd_data | (WORD_BITS'(1) << w_zero_idx);
            end
            S_RD: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = r_q;
            end
            S_CHK: begin
                o_mem_wr_addr = r_q;
                if (r_mode == MODE_FREE) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_data = i_mem_rd_data & ~w_bit_mask;
                end else begin
                    o_mem_wr_en   = !w_hit;
                    o_mem_wr_data = i_mem_rd_data | w_bit_mask;
                end
            end
            default: begin
                o_mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset runs the same sweep as init, with no frames reserved.
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_base     <= '0;
            r_n        <= '0;
            r_init_req <= 1'b0;
            r_dv       <= 1'b0;
            r_last_iss <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    r_base <= r_base + WB_STEP;
                    if (r_addr == LAST_WORD) begin
                        r_state <= r_init_req ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_mode <= i_req.mode;
                        r_pf   <= i_req.page_frame;
                        unique case (i_req.mode)
                            MODE_ALLOC: begin
                                if (i_req.page_frame != '0) begin
                                    r_res   <= '{i_req.page_frame, 1'b0, ST_SKIPPED};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_addr     <= '0;
                                    r_base     <= '0;
                                    r_dv       <= 1'b0;
                                    r_last_iss <= 1'b0;
                                    r_state    <= S_SCAN;
                                end
                            end
                            MODE_FREE: begin
                                if (i_req.page_frame == '0) begin
                                    r_res   <= '{'0, 1'b0, ST_SKIPPED};
                                    r_state <= S_EMIT;
                                end else if (w_pf_range) begin
                                    r_res   <= '{i_req.page_frame, 1'b0, ST_RANGE};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_q     <= AW'(i_req.page_frame >> BW);
                                    r_rem   <= i_req.page_frame[BW-1:0];
                                    r_state <= S_RD;
                                end
                            end
                            MODE_AT: begin
                                if (w_at_range) begin
                                    r_res   <= '{i_req.page_frame, 1'b0, ST_RANGE};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_frame <= FCW'(w_at_frame);
                                    r_q     <= AW'(w_at_frame >> BW);
                                    r_rem   <= w_at_frame[BW-1:0];
                                    r_state <= S_RD;
                                end
                            end
                            MODE_INIT: begin
                                r_n        <= w_n_cap;
                                r_addr     <= '0;
                                r_base     <= '0;
                                r_init_req <= 1'b1;
                                r_res      <= '{'0, 1'b0, ST_INIT};
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_mode == MODE_FREE) begin
                        r_res <= '{'0, 1'b0, ST_FREED};
                    end else if (w_hit) begin
                        r_res <= '{r_pf, 1'b0, ST_TAKEN};
                    end else begin
                        r_res <= '{FRAME_W'(r_frame), 1'b1, ST_ALLOCATED};
                    end
                    r_state <= S_EMIT;
                end
                S_SCAN: begin
                    // Reads are issued one word ahead of the word being checked.
                    r_dv <= !r_last_iss;
                    if (!r_last_iss) begin
                        r_addr     <= r_addr + AW'(1);
                        r_base     <= r_base + WB_STEP;
                        r_caddr    <= r_addr;
                        r_cbase    <= r_base;
                        r_last_iss <= (r_addr == LAST_WORD);
                    end
                    if (r_dv) begin
                        if (!w_full) begin
                            r_res   <= '{FRAME_W'(r_cbase + FCW'(w_zero_idx)), 1'b1,
                                         ST_ALLOCATED};
                            r_state <= S_EMIT;
                        end else if (r_caddr == LAST_WORD) begin
                            r_res   <= '{'0, 1'b0, ST_FULL};
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_res_ready) begin
                        r_init_req <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

endmodule

### rtl/bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// Physical page-frame allocator with the frame bitmap held in a RAM.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (mode in tuser, page frame and
// requested address in tdata); one result per request leaves on m_axis
// (frame in tdata, mapped flag and status in tuser). The kernel end address
// is to be written through i_cfg_we / i_cfg_wdata only while the unit is
// idle; the unit itself does not enforce this. One request is in work at a
// time. Skipped and out-of-range requests go straight to their result.
// Allocate reads the bitmap one word per cycle from word 0 up to the word
// that holds the lowest free frame, or through the whole map when it is
// full, and writes that word back with the frame's bit set. Free does one
// read and one write; allocate-at does one read and writes only when the
// frame is free; init writes the whole map, one word written per cycle.
// s_axis_tready rises as the result enters the output register. After
// reset the bitmap is cleared by a sweep over all MAP_WORDS words, during
// which s_axis_tready stays low; the kernel end register resets to zero.
// A finished result waits in the output register while the next request
// is worked on; a stalled receiver holds the unit once a second result is
// ready.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
    parameter int MAP_WORDS  = bfa_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF,
    parameter int PAGE_SHIFT = bfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::KEND_W-1:0]  i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // page_frame[11:0], req_addr[43:12]
    input  logic [1:0]                  s_axis_tuser,  // mode[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // frame_out[11:0]
    output logic [3:0]                  m_axis_tuser   // page_mapped[0], status[3:1]
);

    import bfa_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [KEND_W-1:0]    r_kend;
    logic                 r_out_valid;
    t_result              r_out;

    t_req                 w_req;
    t_result              w_res;
    logic                 w_res_valid;
    logic                 w_res_ready;
    logic                 w_res_fire;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic [WORD_BITS-1:0] w_rd_data;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [WORD_BITS-1:0] w_wr_data;

    always_comb begin
        w_req.mode       = t_mode'(s_axis_tuser[1:0]);
        w_req.page_frame = s_axis_tdata[11:0];
        w_req.req_addr   = s_axis_tdata[43:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kend <= '0;
        end else if (i_cfg_we) begin
            r_kend <= i_cfg_wdata;
        end
    end

    bfa_ctrl #(
        .MAP_WORDS  (MAP_WORDS),
        .WORD_BITS  (WORD_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kend        (r_kend),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_req         (w_req),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_mem_rd_en   (w_rd_en),
        .o_mem_rd_addr (w_rd_addr),
        .i_mem_rd_data (w_rd_data),
        .o_mem_wr_en   (w_wr_en),
        .o_mem_wr_addr (w_wr_addr),
        .o_mem_wr_data (w_wr_data)
    );

    bfa_mem #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: refilled when empty or when its result is taken.
    assign w_res_ready = !r_out_valid || m_axis_tready;
    assign w_res_fire  = w_res_valid && w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.frame};
    assign m_axis_tuser  = {r_out.status, r_out.mapped};

    // Every request leaves the idle state, so ready drops after each acceptance.
    a_ready_drops : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted on two consecutive cycles");

    // Only a successful allocation maps the page.
    a_mapped_alloc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.mapped |-> r_out.status == ST_ALLOCATED)
        else $error("page mapped without an allocation");

    // A freed page holds no frame afterwards.
    a_freed_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_FREED |-> r_out.frame == '0)
        else $error("free result carries a frame number");

endmodule

### bench/bitmap_frame_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit_tb
// Self-checking bench for the bitmap page-frame allocator. A scoreboard keeps
// its own copy of the frame bitmap and the kernel end register, predicts the
// result of every accepted request and compares each returned result with the
// oldest prediction. Directed requests cover the corner cases, then random
// phases run under different kernel end settings with random idling on both
// streams, a long receiver stall and a full drain mid-phase.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit_tb;
    import bfa_pkg::*;

    localparam int FRAME_COUNT  = MAP_WORDS_DEF * WORD_BITS_DEF;
    localparam int PAGE_SHIFT   = PAGE_SHIFT_DEF;
    localparam int STALL_LEN    = 400;
    localparam int PHASE_ITEMS  = 270;
    localparam int NUM_PHASES   = 7;

    class frame_alloc_scoreboard;
        bit [FRAME_COUNT-1:0] frame_used;
        bit [KEND_W-1:0]      kernel_end;
        t_result              expected_q[$];
        int unsigned          errors;

        function new();
            frame_used = '0;
            kernel_end = '0;
            errors     = 0;
        endfunction

        function void set_kernel_end(bit [KEND_W-1:0] value);
            kernel_end = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Applies one accepted request to the shadow bitmap and queues its result.
        function t_result note_request(t_mode mode, logic [FRAME_W-1:0] pf,
                                       logic [ADDR_W-1:0] addr);
            t_result     r;
            int unsigned f;
            int unsigned reserved;
            r.frame  = pf;
            r.mapped = 1'b0;
            r.status = ST_SKIPPED;
            case (mode)
                MODE_ALLOC: begin
                    if (pf == 0) begin
                        r.frame  = '0;
                        r.status = ST_FULL;
                        for (f = 0; f < FRAME_COUNT; f++) begin
                            if (!frame_used[f]) begin
                                frame_used[f] = 1'b1;
                                r.frame  = f[FRAME_W-1:0];
                                r.mapped = 1'b1;
                                r.status = ST_ALLOCATED;
                                break;
                            end
                        end
                    end
                end
                MODE_FREE: begin
                    if (pf == 0) begin
                        r.frame = '0;
                    end else if (pf >= FRAME_COUNT) begin
                        r.status = ST_RANGE;
                    end else begin
                        frame_used[pf] = 1'b0;
                        r.frame  = '0;
                        r.status = ST_FREED;
                    end
                end
                MODE_AT: begin
                    f = addr >> PAGE_SHIFT;
                    if (f >= FRAME_COUNT) begin
                        r.status = ST_RANGE;
                    end else if (frame_used[f]) begin
                        r.status = ST_TAKEN;
                    end else begin
                        frame_used[f] = 1'b1;
                        r.frame  = f[FRAME_W-1:0];
                        r.mapped = 1'b1;
                        r.status = ST_ALLOCATED;
                    end
                end
                default: begin
                    frame_used = '0;
                    reserved = (int'(kernel_end) + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
                    if (reserved > FRAME_COUNT)
                        reserved = FRAME_COUNT;
                    for (f = 0; f < reserved; f++)
                        frame_used[f] = 1'b1;
                    r.frame  = '0;
                    r.status = ST_INIT;
                end
            endcase
            expected_q.push_back(r);
            return r;
        endfunction

        function void check_result(logic [FRAME_W-1:0] frame, logic mapped,
                                   logic [STAT_W-1:0] status);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: frame_out %0d page_mapped %0d status %0d",
                       frame, mapped, status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (frame !== want.frame) begin
                $error("frame_out: expected %0d, actual %0d", want.frame, frame);
                errors++;
            end
            if (mapped !== want.mapped) begin
                $error("page_mapped: expected %0d, actual %0d", want.mapped, mapped);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [KEND_W-1:0]  i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata  = '0;  // page_frame[11:0], req_addr[43:12]
    logic [1:0]         s_axis_tuser  = '0;  // mode[1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;        // frame_out[11:0]
    logic [3:0]         m_axis_tuser;        // page_mapped[0], status[3:1]

    frame_alloc_scoreboard sb = new();

    logic [FRAME_W-1:0] held_frames[$];
    bit                 no_idle    = 1'b0;
    bit                 stall_req  = 1'b0;
    bit                 stall_done = 1'b0;
    int                 stall_cnt  = 0;

    bitmap_frame_allocator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold-off once requested.
    always @(posedge i_clk) begin
        if (stall_req && !stall_done) begin
            m_axis_tready <= 1'b0;
            stall_cnt     <= stall_cnt + 1;
            if (stall_cnt == STALL_LEN - 1)
                stall_done <= 1'b1;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[FRAME_W-1:0], m_axis_tuser[0], m_axis_tuser[3:1]);
    end

    task automatic issue(input t_mode mode, input logic [FRAME_W-1:0] pf,
                         input logic [ADDR_W-1:0] addr);
        t_result res;
        while (!no_idle && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, addr, pf};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        res = sb.note_request(mode, pf, addr);
        if (mode == MODE_INIT)
            held_frames.delete();
        else if (res.status == ST_ALLOCATED)
            held_frames.push_back(res.frame);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_kernel_end(input logic [KEND_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_kernel_end(value);
    endtask

    initial begin
        logic [KEND_W-1:0]  kend_list[NUM_PHASES];
        t_mode              mode;
        logic [FRAME_W-1:0] pf;
        logic [ADDR_W-1:0]  addr;
        int unsigned        sel;
        int unsigned        k;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the kernel end at its reset value.
        issue(MODE_ALLOC, 12'h000, 32'h0);
        issue(MODE_ALLOC, 12'h000, 32'hFFFF_FFFF);
        issue(MODE_ALLOC, 12'hFFF, 32'h0);
        issue(MODE_FREE,  12'h000, 32'h0);
        issue(MODE_FREE,  12'h001, 32'h0);
        issue(MODE_FREE,  12'hFFF, 32'h0);
        issue(MODE_AT,    12'h000, 32'h0000_0000);
        issue(MODE_AT,    12'h000, 32'h00FF_F000);
        issue(MODE_AT,    12'h123, 32'h0100_0000);
        issue(MODE_AT,    12'hABC, 32'hFFFF_FFFF);
        issue(MODE_AT,    12'h005, 32'h0000_1234);
        issue(MODE_INIT,  12'h000, 32'h0);
        issue(MODE_ALLOC, 12'h000, 32'h0);

        // Whole map reserved by the kernel: allocation reports full.
        drain_results();
        write_kernel_end(25'h100_0000);
        issue(MODE_INIT,  12'h000, 32'h0);
        issue(MODE_ALLOC, 12'h000, 32'h0);
        issue(MODE_FREE,  12'd100, 32'h0);
        issue(MODE_ALLOC, 12'h000, 32'h0);
        issue(MODE_ALLOC, 12'h000, 32'h0);
        issue(MODE_AT,    12'h000, 32'h00FF_FFFF);

        // Kernel end one byte into the second page reserves two frames.
        drain_results();
        write_kernel_end(25'h000_1001);
        issue(MODE_INIT,  12'hFFF, 32'hFFFF_FFFF);
        issue(MODE_ALLOC, 12'h000, 32'h0);
        issue(MODE_AT,    12'h000, 32'h0000_1FFF);

        kend_list[0] = KEND_W'($urandom_range(25'h100_0000));
        kend_list[1] = 25'h000_0000;
        kend_list[2] = 25'h100_0000;
        kend_list[3] = 25'h0FF_8000;
        kend_list[4] = 25'h000_1FFF;
        kend_list[5] = 25'h000_0001;
        kend_list[6] = KEND_W'($urandom_range(25'h100_0000));

        foreach (kend_list[p]) begin
            drain_results();
            write_kernel_end(kend_list[p]);
            no_idle = (p == 4);
            issue(MODE_INIT, FRAME_W'($urandom_range(4095)), $urandom());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 40)
                    stall_req = 1'b1;
                if (p == 3 && i == 120)
                    drain_results();
                sel  = $urandom_range(99);
                pf   = FRAME_W'($urandom_range(4095));
                addr = $urandom();
                if (sel < 40) begin
                    mode = MODE_ALLOC;
                    if ($urandom_range(9) != 0)
                        pf = '0;
                end else if (sel < 70) begin
                    mode = MODE_FREE;
                    if (held_frames.size() != 0 && $urandom_range(4) != 0) begin
                        k  = $urandom_range(held_frames.size() - 1);
                        pf = held_frames[k];
                        held_frames.delete(k);
                    end else if ($urandom_range(7) == 0) begin
                        pf = '0;
                    end
                end else if (sel < 95) begin
                    mode = MODE_AT;
                    if ($urandom_range(3) != 0)
                        addr = $urandom_range(32'h00FF_FFFF);
                    if ($urandom_range(1) != 0)
                        pf = '0;
                end else begin
                    mode = MODE_INIT;
                end
                issue(mode, pf, addr);
            end
        end

        drain_results();
        repeat (MAP_WORDS_DEF + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/bfa_pkg.sv
rtl/bfa_mem.sv
rtl/bfa_ctrl.sv
rtl/bitmap_frame_allocator_unit.sv
bench/bitmap_frame_allocator_unit_tb.sv
